@@ hw/rtl/ubx_nav_pkg.sv @@
// Shared types, constants and helpers for the navigation frame parser.
// No dependencies; compiled before every other file of the block.
package ubx_nav_pkg;

    localparam int BYTE_W      = 8;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = 7;
    localparam int POS_W       = 7;
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = IDX_W + 1;   // bank bit + payload index
    localparam int Q_DEPTH     = 2;
    localparam int Q_CNT_W     = 2;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd52;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
    localparam logic [BYTE_W-1:0] CLASS_NAV   = 8'h01;
    localparam logic [BYTE_W-1:0] ID_POS_LLH  = 8'h02;
    localparam logic [BYTE_W-1:0] ID_VEL_NED  = 8'h12;
    localparam logic [BYTE_W-1:0] ID_SOL      = 8'h06;
    localparam logic [BYTE_W-1:0] ID_TIME_UTC = 8'h21;

    localparam logic [KIND_W-1:0] KIND_POS_LLH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VEL_NED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOL      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIME_UTC = 2'd3;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_SYNC1   = 7'd0;
    localparam logic [POS_W-1:0] POS_SYNC2   = 7'd1;
    localparam logic [POS_W-1:0] POS_CLASS   = 7'd2;
    localparam logic [POS_W-1:0] POS_ID      = 7'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 7'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 7'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 7'd6;

    typedef struct packed {
        logic              known;
        logic [KIND_W-1:0] kind;
    } kind_t;

    // frame descriptor handed from front to back
    typedef struct packed {
        logic              bank;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
    } desc_t;

    // payload store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } store_wr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } back_state_t;

    function automatic kind_t kind_of(input logic [BYTE_W-1:0] id);
        kind_t k;
        k.known = 1'b1;
        case (id)
            ID_POS_LLH:  k.kind = KIND_POS_LLH;
            ID_VEL_NED:  k.kind = KIND_VEL_NED;
            ID_SOL:      k.kind = KIND_SOL;
            ID_TIME_UTC: k.kind = KIND_TIME_UTC;
            default:
            begin
                k.known = 1'b0;
                k.kind  = KIND_POS_LLH;
            end
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/ubx_nav_if.sv @@
// Valid/ready channel interfaces for received bytes and payload words.
// Depends on ubx_nav_pkg for field widths.
interface ubx_nav_rx_if import ubx_nav_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubx_nav_res_if import ubx_nav_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] msg_kind;
    logic [LEN_W-1:0]  payload_len;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;

    modport source (output valid, output msg_kind, output payload_len, output byte_index,
                    output payload_byte, output last, input ready);
    modport sink (input valid, input msg_kind, input payload_len, input byte_index,
                  input payload_byte, input last, output ready);
endinterface

@@ hw/rtl/ubx_nav_front.sv @@
// Frame recognizer: sync/header checks, Fletcher sums, payload store writes.
// Depends on ubx_nav_pkg and ubx_nav_rx_if; pushes descriptors of good frames.
module ubx_nav_front import ubx_nav_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    ubx_nav_rx_if.sink       rx,
    input  logic             q_full,
    output logic             push,
    output desc_t            push_desc,
    output store_wr_t        store_wr
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic [LEN_W-1:0]  max_len_reg;
    logic              bank_reg, bank_next;

    logic [LEN_W-1:0]  limit;
    logic [POS_W-1:0]  end_pos;
    logic              in_payload;
    logic              at_sum_b;
    logic [BYTE_W-1:0] add_a;
    logic [BYTE_W-1:0] add_b;
    kind_t             kind;

    always_comb
    begin
        limit      = (max_len_reg > LEN_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : max_len_reg;
        end_pos    = POS_PAYLOAD + POS_W'(len_reg);
        in_payload = (pos_reg >= POS_PAYLOAD) && (pos_reg < end_pos);
        at_sum_b   = pos_reg > end_pos;
        add_a      = sum_a_reg + rx.rx_byte;
        add_b      = sum_b_reg + add_a;
        kind       = kind_of(id_reg);

        // hold off bytes that need a free bank or a queue slot
        rx.ready   = !(q_full && (in_payload || at_sum_b));

        pos_next   = pos_reg;
        len_next   = len_reg;
        id_next    = id_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        bank_next  = bank_reg;
        push       = 1'b0;
        push_desc.bank = bank_reg;
        push_desc.kind = kind.kind;
        push_desc.len  = len_reg;
        store_wr.en    = 1'b0;
        store_wr.addr  = {bank_reg, IDX_W'(pos_reg - POS_PAYLOAD)};
        store_wr.data  = rx.rx_byte;

        if (rx.valid && rx.ready)
        begin
            pos_next = pos_reg + POS_W'(1);
            case (pos_reg)
                POS_SYNC1:
                begin
                    if (rx.rx_byte != SYNC_FIRST)
                        pos_next = POS_SYNC1;
                end
                POS_SYNC2:
                begin
                    if (rx.rx_byte != SYNC_SECOND)
                        pos_next = POS_SYNC1;
                end
                POS_CLASS:
                begin
                    if (rx.rx_byte != CLASS_NAV)
                        pos_next = POS_SYNC1;
                    sum_a_next = rx.rx_byte;
                    sum_b_next = rx.rx_byte;
                end
                POS_ID:
                begin
                    id_next    = rx.rx_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                POS_LEN_LO:
                begin
                    if (rx.rx_byte > {1'b0, limit})
                        pos_next = POS_SYNC1;
                    len_next   = rx.rx_byte[LEN_W-1:0];
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                POS_LEN_HI:
                begin
                    if (rx.rx_byte != '0)
                        pos_next = POS_SYNC1;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                default:
                begin
                    if (in_payload)
                    begin
                        store_wr.en = 1'b1;
                        sum_a_next  = add_a;
                        sum_b_next  = add_b;
                    end
                    else if (pos_reg == end_pos)
                    begin
                        if (rx.rx_byte != sum_a_reg)
                            pos_next = POS_SYNC1;
                    end
                    else
                    begin
                        pos_next = POS_SYNC1;
                        if ((rx.rx_byte == sum_b_reg) && kind.known)
                        begin
                            push      = 1'b1;
                            bank_next = ~bank_reg;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_SYNC1;
            len_reg     <= '0;
            id_reg      <= '0;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            bank_reg    <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            bank_reg  <= bank_next;
            if (cfg_we)
                max_len_reg <= cfg_wdata;
        end
    end

endmodule

@@ hw/rtl/ubx_nav_desc_q.sv @@
// Two-entry descriptor queue between the frame recognizer and the replay side.
// Depends on ubx_nav_pkg; the head entry stays put until its run is done.
module ubx_nav_desc_q import ubx_nav_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  full,
    output logic  empty
);

    desc_t              entry_reg [Q_DEPTH];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + Q_CNT_W'(1);
                2'b01:   count_reg <= count_reg - Q_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("descriptor pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("descriptor popped from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + Q_CNT_W'(1)))
        else $error("queue count did not follow push");

    // banks alternate, so the head always reads the bank the writer is not filling
    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == Q_CNT_W'(1)) |-> (entry_reg[rd_ptr_reg].bank != push_desc.bank))
        else $error("head descriptor shares the bank being written");

endmodule

@@ hw/rtl/ubx_nav_back.sv @@
// Replay side: payload store (two banks) and the result word sequencer.
// Depends on ubx_nav_pkg and ubx_nav_res_if; consumes queued descriptors.
module ubx_nav_back import ubx_nav_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  store_wr_t  store_wr,
    input  desc_t      head,
    input  logic       q_empty,
    output logic       pop,
    ubx_nav_res_if.source res
);

    logic [BYTE_W-1:0] mem [2*STORE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_en;

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              is_last;
    logic              is_empty;

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            mem[store_wr.addr] <= store_wr.data;
        if (rd_en)
            rd_data_reg <= mem[{head.bank, idx_reg}];
    end

    always_comb
    begin
        is_empty = head.len == '0;
        is_last  = is_empty || ((LEN_W'(idx_reg) + LEN_W'(1)) == head.len);

        res.msg_kind     = head.kind;
        res.payload_len  = head.len;
        res.byte_index   = idx_reg;
        res.payload_byte = is_empty ? '0 : rd_data_reg;
        res.last         = is_last;

        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        pop        = 1'b0;
        res.valid  = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                idx_next = '0;
                if (!q_empty)
                    state_next = is_empty ? BK_SHOW : BK_READ;
            end
            BK_READ:
            begin
                rd_en      = 1'b1;
                state_next = BK_SHOW;
            end
            BK_SHOW:
            begin
                res.valid = 1'b1;
                if (res.ready)
                begin
                    if (is_last)
                    begin
                        pop        = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ hw/rtl/ubx_nav_frame_parser.sv @@
// Top level of the navigation frame parser: recognizer, descriptor queue, replay.
// Depends on ubx_nav_pkg, ubx_nav_if, ubx_nav_front, ubx_nav_desc_q, ubx_nav_back.
//
//  channel  dir  handshake       word
//  rx       in   valid/ready     rx_byte
//  res      out  valid/ready     msg_kind, payload_len, byte_index, payload_byte, last
//  cfg      in   cfg_we          cfg_wdata = max_payload_len
//
// A received byte is taken whenever rx.ready is high; rx.ready drops only on payload and final
// checksum bytes while both payload banks hold frames not yet replayed.
// Replay reads each payload byte from the store into an output register, then shows it, and
// reads the next byte only after res takes the current word; each run starts from idle.
// Reset clears parser position, sums, queue and sequencer; the store needs no clearing.
// A stall on res holds the current word and backs up into the queue, and into rx
// once the queue is full.
module ubx_nav_frame_parser import ubx_nav_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    ubx_nav_rx_if.sink       rx,
    ubx_nav_res_if.source    res
);

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    desc_t     push_desc;
    desc_t     head;
    store_wr_t store_wr;

    ubx_nav_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .store_wr  (store_wr)
    );

    ubx_nav_desc_q u_desc_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    ubx_nav_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .store_wr (store_wr),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .res      (res)
    );

endmodule
